// ===== hdl/eth_pkg.sv =====
// Package for the edge table histogram: field types, opcodes and sizes.
`default_nettype none
package eth_pkg;
	localparam int MAX_EDGES = 64;
	localparam int COUNT_BITS = 32;
	localparam int SLOT_BITS = 6;
	localparam int FIFO_DEPTH = 2;
	localparam logic [5:0] BIN_COUNT_RESET = 6'd38;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		OP_WRITE_EDGE = 3'd0,
		OP_SAMPLE     = 3'd1,
		OP_END_STA    = 3'd2,
		OP_READ_BIN   = 3'd3,
		OP_CLEAR      = 3'd4
	} opcode_t;

	localparam logic [1:0] REG_COUNT_SCANS  = 2'd0;
	localparam logic [1:0] REG_PROFILE_MODE = 2'd1;
	localparam logic [1:0] REG_BIN_COUNT    = 2'd2;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [5:0]        slot;
		logic signed [31:0] sample_value;
		logic [15:0]       weight;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  bin_index;
		logic        in_range;
		logic [31:0] bin_total;
	} out_item_t;

	// Classified command passed from the front part to the back part.
	typedef struct packed {
		logic [2:0]  opcode;
		logic [5:0]  slot;
		logic        in_range;
		logic [15:0] amount;
		logic        set_flag;
		logic        add;
	} cmd_t;

	typedef enum logic [2:0] {
		FS_IDLE, FS_SEARCH, FS_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		BS_IDLE, BS_READ, BS_UPDATE, BS_SWEEP_RD, BS_SWEEP_WR, BS_OUT
	} back_state_t;
endpackage
`default_nettype wire

// ===== hdl/edge_table_histogram.sv =====
// Top level of the edge table histogram engine.
// A sample is searched edge by edge from bin 0 up, stopping at the first matching bin.
// An end of station sweeps all bins, each with a read state and then a write state.
// One edge is compared per cycle; a two-entry queue lets the search overlap the back part.
// Reset clears control, counts, flags and configuration; edges are undefined until written.
`default_nettype none
module edge_table_histogram import eth_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_data,
	input  wire logic      in_valid,
	output logic           in_ready,
	output out_item_t      out_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire logic      cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [5:0] cfg_data
);
	logic count_scans_q, profile_mode_q;
	logic [5:0] bin_count_q;
	cmd_t f_cmd, b_cmd;
	logic f_valid, f_ready, b_valid, b_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_scans_q <= 1'b0;
			profile_mode_q <= 1'b1;
			bin_count_q <= BIN_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COUNT_SCANS: count_scans_q <= cfg_data[0];
				REG_PROFILE_MODE: profile_mode_q <= cfg_data[0];
				REG_BIN_COUNT: bin_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	eth_front u_front (.clk, .arst_n, .in_item(in_data), .in_valid, .in_ready,
		.count_scans(count_scans_q), .profile_mode(profile_mode_q),
		.bin_count(bin_count_q), .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready));

	eth_fifo u_fifo (.clk, .arst_n, .wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(b_cmd), .rd_valid(b_valid), .rd_ready(b_ready));

	eth_back u_back (.clk, .arst_n, .cmd(b_cmd), .cmd_valid(b_valid), .cmd_ready(b_ready),
		.out_item(out_data), .out_valid, .out_ready);
endmodule
`default_nettype wire

// ===== hdl/eth_front.sv =====
// Front part: writes edges and searches the edge table for a sample's bin.
`default_nettype none
module eth_front import eth_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t in_item,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     count_scans,
	input  wire logic     profile_mode,
	input  wire logic [5:0] bin_count,
	output cmd_t          cmd,
	output logic          cmd_valid,
	input  wire logic     cmd_ready
);
	front_state_t state_q, state_d;
	logic signed [31:0] edges_q [MAX_EDGES];
	logic signed [31:0] edge_s1;
	logic signed [31:0] prev_q;
	in_item_t item_q;
	logic [6:0] ptr_q;
	logic found_q;
	logic [5:0] found_bin_q;
	logic [5:0] limit;
	logic hit;
	logic last;

	// Search limit: only bins below the last edge exist.
	assign limit = (bin_count > 6'(MAX_EDGES - 1)) ? 6'(MAX_EDGES - 1) : bin_count;

	// The edge read at ptr_q arrives in the next cycle, so bin ptr_q - 2 is tested
	// against the previous edge and the edge just read.
	assign hit = (ptr_q >= 7'd2) && (item_q.sample_value >= prev_q) &&
		(item_q.sample_value < edge_s1);
	assign last = (limit == 6'd0) || (ptr_q == {1'b0, limit} + 7'd1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: if (in_valid) state_d = (in_item.opcode == OP_SAMPLE) ? FS_SEARCH : FS_PUSH;
			FS_SEARCH: if (hit || last) state_d = FS_PUSH;
			FS_PUSH: if (cmd_ready) state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = (state_q == FS_IDLE);
		cmd_valid = (state_q == FS_PUSH);
		cmd.opcode = item_q.opcode;
		cmd.slot = (item_q.opcode == OP_SAMPLE) ? found_bin_q : item_q.slot;
		cmd.in_range = (item_q.opcode == OP_SAMPLE) && found_q;
		cmd.amount = (!profile_mode && count_scans) ? item_q.weight : 16'd1;
		cmd.set_flag = profile_mode && !count_scans;
		cmd.add = (item_q.opcode == OP_SAMPLE) && found_q && !cmd.set_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Edge table with registered read; one edge read per cycle, lowest matching bin wins.
	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && in_valid) begin
			item_q <= in_item;
			ptr_q <= '0;
			found_q <= 1'b0;
			found_bin_q <= '0;
			if (in_item.opcode == OP_WRITE_EDGE)
				edges_q[in_item.slot] <= in_item.sample_value;
		end else if (state_q == FS_SEARCH) begin
			edge_s1 <= edges_q[ptr_q[5:0]];
			prev_q <= edge_s1;
			ptr_q <= ptr_q + 7'd1;
			if (hit) begin
				found_q <= 1'b1;
				found_bin_q <= 6'(ptr_q - 7'd2);
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/eth_fifo.sv =====
// Short queue of classified commands between the front and back parts.
`default_nettype none
module eth_fifo import eth_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t wr_data,
	input  wire logic wr_valid,
	output logic      wr_ready,
	output cmd_t      rd_data,
	output logic      rd_valid,
	input  wire logic rd_ready
);
	cmd_t mem_q [FIFO_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != 2'(FIFO_DEPTH));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

// ===== hdl/eth_back.sv =====
// Back part: updates counts and flags, sweeps stations, answers reads.
`default_nettype none
module eth_back import eth_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	input  wire logic  cmd_valid,
	output logic       cmd_ready,
	output out_item_t  out_item,
	output logic       out_valid,
	input  wire logic  out_ready
);
	back_state_t state_q, state_d;
	logic [COUNT_BITS-1:0] counts_q [MAX_EDGES];
	logic [MAX_EDGES-1:0] used_q;
	logic [MAX_EDGES-1:0] flags_q;
	cmd_t cmd_q;
	logic [5:0] sw_q;
	logic [5:0] rd_addr;
	logic [COUNT_BITS-1:0] rd_s1;
	logic used_s1;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] amt;
	logic [COUNT_BITS:0] sum;
	logic wr_en;
	logic [5:0] wr_addr;
	logic [COUNT_BITS-1:0] wr_val;
	out_item_t res_q;

	// A count entry not written since the last clear reads as zero.
	assign rd_addr = (state_q == BS_SWEEP_RD) ? sw_q : cmd_q.slot;
	assign cur = used_s1 ? rd_s1 : '0;
	assign amt = (state_q == BS_SWEEP_WR) ? COUNT_BITS'(1) : COUNT_BITS'(cmd_q.amount);
	assign sum = {1'b0, cur} + {1'b0, amt};
	assign wr_val = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
	assign wr_en = (state_q == BS_UPDATE && cmd_q.add) ||
		(state_q == BS_SWEEP_WR && flags_q[sw_q]);
	assign wr_addr = (state_q == BS_SWEEP_WR) ? sw_q : cmd_q.slot;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: if (cmd_valid) begin
				if (cmd.opcode == OP_END_STA) state_d = BS_SWEEP_RD;
				else if (cmd.add || cmd.opcode == OP_READ_BIN) state_d = BS_READ;
				else state_d = BS_OUT;
			end
			BS_READ: state_d = BS_UPDATE;
			BS_UPDATE: state_d = BS_OUT;
			BS_SWEEP_RD: state_d = BS_SWEEP_WR;
			BS_SWEEP_WR: state_d = (sw_q == 6'(MAX_EDGES - 1)) ? BS_OUT : BS_SWEEP_RD;
			BS_OUT: if (out_ready) state_d = BS_IDLE;
			default: state_d = BS_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd_ready = (state_q == BS_IDLE);
		out_valid = (state_q == BS_OUT);
		out_item = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			flags_q <= '0;
			used_q <= '0;
		end else begin
			state_q <= state_d;
			// Flags and count marks change per command.
			if (state_q == BS_IDLE && cmd_valid) begin
				if (cmd.opcode == OP_CLEAR) begin
					flags_q <= '0;
					used_q <= '0;
				end else if (cmd.in_range && cmd.set_flag)
					flags_q[cmd.slot] <= 1'b1;
			end else if (state_q == BS_SWEEP_WR) begin
				flags_q[sw_q] <= 1'b0;
			end
			if (wr_en) used_q[wr_addr] <= 1'b1;
		end
	end

	// Count memory with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) counts_q[wr_addr] <= wr_val;
		if (state_q == BS_READ || state_q == BS_SWEEP_RD) begin
			rd_s1 <= counts_q[rd_addr];
			used_s1 <= used_q[rd_addr];
		end
	end

	// Command capture, sweep index and the result beat.
	always_ff @(posedge clk) begin
		if (state_q == BS_IDLE && cmd_valid) begin
			cmd_q <= cmd;
			sw_q <= '0;
			res_q.bin_index <= cmd.in_range ? cmd.slot : 6'd0;
			res_q.in_range <= cmd.in_range;
			res_q.bin_total <= '0;
		end
		if (state_q == BS_UPDATE && cmd_q.opcode == OP_READ_BIN)
			res_q.bin_total <= 32'(cur);
		if (state_q == BS_SWEEP_WR) sw_q <= sw_q + 6'd1;
	end

	// Station sweep leaves no flag behind.
	a_sweep_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_SWEEP_WR && sw_q == 6'(MAX_EDGES - 1)) |=> (flags_q == '0))
		else $error("flags left after station sweep");
	a_one_owner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !cmd_ready) else $error("accepting while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(res_q)))
		else $error("result dropped");
endmodule
`default_nettype wire

// ===== verif/edge_table_histogram_tb.sv =====
// Self-checking testbench for the edge table histogram engine.
`timescale 1ns / 100ps
`default_nettype none
module edge_table_histogram_tb;
	import eth_pkg::*;

	logic clk;
	logic arst_n;
	in_item_t in_data;
	logic in_valid;
	logic in_ready;
	out_item_t out_data;
	logic out_valid;
	logic out_ready;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;

	edge_table_histogram uut (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
		.out_data(out_data), .out_valid(out_valid), .out_ready(out_ready),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state and configuration.
	logic signed [31:0] edges_m [MAX_EDGES];
	logic [COUNT_BITS-1:0] counts_m [MAX_EDGES];
	logic flags_m [MAX_EDGES];
	logic scans_m;
	logic profile_m;
	logic [5:0] bins_m;

	out_item_t expected_q [$];
	int errors;
	int cycles;
	bit quiet;          // when set, both sides run with no idling

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Cycle counter and timeout.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1500000) begin
				$display("edge_table_histogram_tb NOT OK");
				$finish;
			end
		end
	end

	function automatic void add_count(int b, logic [15:0] amt);
		logic [COUNT_BITS:0] s;
		s = {1'b0, counts_m[b]} + (COUNT_BITS + 1)'(amt);
		counts_m[b] = s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	// Work out the result of one command and update the predicted state.
	function automatic out_item_t predict_bin(in_item_t it);
		out_item_t r;
		int lim;
		int found;
		r = '0;
		found = -1;
		case (it.opcode)
			OP_WRITE_EDGE: begin
				edges_m[it.slot] = it.sample_value;
			end
			OP_SAMPLE: begin
				lim = (bins_m > MAX_EDGES - 1) ? MAX_EDGES - 1 : bins_m;
				for (int i = 0; i < lim; i++)
					if (found < 0 && it.sample_value >= edges_m[i] &&
							it.sample_value < edges_m[i+1])
						found = i;
				if (found >= 0) begin
					r.bin_index = found[5:0];
					r.in_range = 1'b1;
					if (!profile_m)
						add_count(found, scans_m ? it.weight : 16'd1);
					else if (scans_m)
						add_count(found, 16'd1);
					else
						flags_m[found] = 1'b1;
				end
			end
			OP_END_STA: begin
				for (int i = 0; i < MAX_EDGES; i++) begin
					if (flags_m[i])
						add_count(i, 16'd1);
					flags_m[i] = 1'b0;
				end
			end
			OP_READ_BIN: r.bin_total = counts_m[it.slot];
			OP_CLEAR: begin
				for (int i = 0; i < MAX_EDGES; i++) begin
					counts_m[i] = '0;
					flags_m[i] = 1'b0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic bit idle_now();
		return !quiet && ($urandom_range(99) < 28);
	endfunction

	// Send one command beat and queue its expected result. Valid stays high after
	// the accepting edge only until the next beat or an idle cycle replaces it.
	task automatic send_cmd(in_item_t it);
		if (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (idle_now()) @(posedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		expected_q.push_back(predict_bin(it));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_op(logic [2:0] op, logic [5:0] slot, logic signed [31:0] v,
			logic [15:0] w);
		in_item_t it;
		it.opcode = op;
		it.slot = slot;
		it.sample_value = v;
		it.weight = w;
		send_cmd(it);
	endtask

	// Result receiver with random stalls.
	always @(posedge clk) begin
		out_item_t e;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result beat with no expectation");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_data.bin_index !== e.bin_index) begin
					$error("bin_index exp %0d got %0d", e.bin_index, out_data.bin_index);
					errors++;
				end
				if (out_data.in_range !== e.in_range) begin
					$error("in_range exp %0d got %0d", e.in_range, out_data.in_range);
					errors++;
				end
				if (out_data.bin_total !== e.bin_total) begin
					$error("bin_total exp %0d got %0d", e.bin_total, out_data.bin_total);
					errors++;
				end
			end
		end
		out_ready <= !idle_now();
	end

	// Stop sending, wait for all results, then idle before returning.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [5:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_COUNT_SCANS: scans_m = val[0];
			REG_PROFILE_MODE: profile_m = val[0];
			REG_BIN_COUNT: bins_m = val;
			default: ;
		endcase
	endtask

	task automatic set_mode(logic scans, logic prof, logic [5:0] nb);
		write_reg(REG_COUNT_SCANS, {5'd0, scans});
		write_reg(REG_PROFILE_MODE, {5'd0, prof});
		write_reg(REG_BIN_COUNT, nb);
	endtask

	// Load a sorted edge table of all 64 entries with random spacing.
	task automatic load_edges(bit wide);
		logic signed [31:0] v;
		v = wide ? 32'sh8000_0000 : -32'sd40000;
		for (int i = 0; i < MAX_EDGES; i++) begin
			send_op(OP_WRITE_EDGE, i[5:0], v, 16'($urandom));
			if (wide)
				v = v + $signed({1'b0, 31'($urandom_range(32'h0200_0000, 32'h0010_0000))});
			else
				v = v + $urandom_range(2000, 0);
		end
	endtask

	function automatic logic signed [31:0] pick_value();
		int k;
		k = $urandom_range(9);
		if (k == 0) return $urandom;
		if (k == 1) return edges_m[$urandom_range(MAX_EDGES - 1)];
		return edges_m[$urandom_range(bins_m)] + $signed(32'($urandom_range(3000))) - 100;
	endfunction

	task automatic test_directed();
		load_edges(1'b1);
		set_mode(1'b1, 1'b0, 6'd63);
		send_op(OP_SAMPLE, 6'd0, 32'sh8000_0000, 16'hFFFF);
		send_op(OP_SAMPLE, 6'd63, 32'sh7FFF_FFFF, 16'hFFFF);
		send_op(OP_SAMPLE, 6'd0, edges_m[62], 16'd0);
		send_op(OP_SAMPLE, 6'd0, edges_m[63], 16'd7);
		send_op(OP_READ_BIN, 6'd0, 32'sd0, 16'd0);
		send_op(OP_READ_BIN, 6'd62, 32'sd0, 16'd0);
		send_op(OP_READ_BIN, 6'd63, 32'sd0, 16'd0);
		// Unsorted edges: the lowest matching bin wins.
		send_op(OP_WRITE_EDGE, 6'd5, edges_m[2], 16'd0);
		send_op(OP_SAMPLE, 6'd0, edges_m[2], 16'd1);
		send_op(3'd5, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF);
		send_op(3'd7, 6'h2A, 32'h5555_5555, 16'h5555);
		send_op(3'd6, 6'd0, 32'sd0, 16'd0);
		set_mode(1'b0, 1'b1, 6'd1);
		send_op(OP_SAMPLE, 6'd0, edges_m[0], 16'd0);
		send_op(OP_SAMPLE, 6'd0, edges_m[1], 16'd0);
		send_op(OP_END_STA, 6'd0, 32'sd0, 16'd0);
		send_op(OP_READ_BIN, 6'd0, 32'sd0, 16'd0);
		send_op(OP_CLEAR, 6'd0, 32'sd0, 16'd0);
		send_op(OP_READ_BIN, 6'd0, 32'sd0, 16'd0);
	endtask

	// Large weights accumulate back to back into one bin.
	task automatic test_weights();
		load_edges(1'b0);
		set_mode(1'b1, 1'b0, 6'd4);
		quiet = 1'b1;
		repeat (100) send_op(OP_SAMPLE, 6'd0, edges_m[1], 16'hFFFF);
		quiet = 1'b0;
		send_op(OP_READ_BIN, 6'd1, 32'sd0, 16'd0);
	endtask

	task automatic test_random(int n, bit calm);
		int k;
		logic [5:0] nb;
		quiet = calm;
		for (int p = 0; p < n / 250; p++) begin
			nb = (p % 4 == 0) ? 6'd63 : (p % 4 == 1) ? 6'd1 : 6'($urandom_range(63, 1));
			set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), nb);
			if (p % 3 == 0) load_edges(1'($urandom_range(1)));
			for (int j = 0; j < 250; j++) begin
				k = $urandom_range(99);
				if (k < 60)
					send_op(OP_SAMPLE, 6'($urandom), pick_value(), 16'($urandom));
				else if (k < 72)
					send_op(OP_END_STA, 6'($urandom), $urandom, 16'($urandom));
				else if (k < 90)
					send_op(OP_READ_BIN, 6'($urandom), $urandom, 16'($urandom));
				else if (k < 93)
					send_op(OP_CLEAR, 6'($urandom), $urandom, 16'($urandom));
				else if (k < 96)
					send_cmd('{3'($urandom_range(7, 5)), 6'($urandom), $urandom,
						16'($urandom)});
				else
					send_op(OP_WRITE_EDGE, 6'($urandom), pick_value(), 16'($urandom));
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		errors = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		scans_m = 1'b0;
		profile_m = 1'b1;
		bins_m = BIN_COUNT_RESET;
		for (int i = 0; i < MAX_EDGES; i++) begin
			edges_m[i] = '0;
			counts_m[i] = '0;
			flags_m[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_directed();
		test_weights();
		test_random(500, 1'b1);
		test_random(1000, 1'b0);
		drain();
		if (errors == 0)
			$display("edge_table_histogram_tb OK");
		else
			$display("edge_table_histogram_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/eth_pkg.sv
hdl/eth_front.sv
hdl/eth_fifo.sv
hdl/eth_back.sv
hdl/edge_table_histogram.sv
verif/edge_table_histogram_tb.sv
